// ----- rtl/gqi_pkg.sv -----
// Shared constants, types and term tables for the gyro quaternion integrator.
`default_nettype none
package gqi_pkg;

    localparam int RATE_W  = 16;
    localparam int Q_W     = 32;
    localparam int TS_W    = 24;
    localparam logic [TS_W-1:0] TS_RESET = 24'd16777;

    // Q1.30 one
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sd1073741824;

    // serial multiplier geometry: multiplicand AW bits, multiplier up to BW bits
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 31;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_NB = $clog2(MUL_BW + 1);

    localparam int P_W  = 48;   // Hamilton product sum, Q.41
    localparam int V_W  = 37;   // q + delta, Q.30
    localparam int MG_W = 36;   // |v|
    localparam int MS_W = 31;   // |v| after normalising shift
    localparam int N_W  = 64;   // sum of squares
    localparam int R_W  = 32;   // integer square root

    localparam logic [N_W-1:0] COLLAPSE_TH = 64'd1152921504607;

    typedef struct packed {
        logic              start;
        logic [MUL_NB-1:0] nbits;
    } mul_ctl_t;

    // product terms, index = component*3 + term
    function automatic logic [1:0] term_q(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0: r = 2'd1;  4'd1: r = 2'd2;  4'd2: r = 2'd3;
            4'd3: r = 2'd0;  4'd4: r = 2'd2;  4'd5: r = 2'd3;
            4'd6: r = 2'd0;  4'd7: r = 2'd1;  4'd8: r = 2'd3;
            4'd9: r = 2'd0;  4'd10: r = 2'd1; 4'd11: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] term_w(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0: r = 2'd0;  4'd1: r = 2'd1;  4'd2: r = 2'd2;
            4'd3: r = 2'd0;  4'd4: r = 2'd2;  4'd5: r = 2'd1;
            4'd6: r = 2'd1;  4'd7: r = 2'd2;  4'd8: r = 2'd0;
            4'd9: r = 2'd2;  4'd10: r = 2'd1; 4'd11: r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic term_neg(input logic [3:0] k);
        logic r;
        unique case (k)
            4'd0, 4'd1, 4'd2, 4'd5, 4'd7, 4'd11: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gqi_serial_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module gqi_serial_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gqi_pkg::mul_ctl_t             ctl,
    input  wire logic [gqi_pkg::MUL_AW-1:0]    a,
    input  wire logic [gqi_pkg::MUL_BW-1:0]    b,
    output logic                               busy,
    output logic [gqi_pkg::MUL_PW-1:0]         product
);

    localparam int AW = gqi_pkg::MUL_AW;
    localparam int BW = gqi_pkg::MUL_BW;
    localparam int NB = gqi_pkg::MUL_NB;
    localparam logic [NB-1:0] BW_N = NB'(BW);

    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic [NB-1:0] cnt_reg, cnt_next;
    logic [NB-1:0] nb_reg, nb_next;
    logic          busy_reg, busy_next;
    logic [AW:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        nb_next   = nb_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = ctl.nbits;
            nb_next   = ctl.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[AW:1];
            lo_next  = {sum[0], lo_reg[BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NB'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        nb_reg <= nb_next;
    end

    // for an n-bit multiplier the product sits in the top AW+n bits
    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg} >> (BW_N - nb_reg);

endmodule
`default_nettype wire

// ----- rtl/gyro_quaternion_integrator_top.sv -----
// Top level of the gyro quaternion integrator: sequencer, root and divider.
// Work per sample: 12 x 16-bit, 4 x 24-bit and 4 x 31-bit serial multiplies, a 32-step
//   square root and four 31-step divides.
// Samples: one at a time; in_stall stays high until the result is written, and the work
//   is paced by the shared bit-serial multiplier and the one-bit-per-cycle root and divider.
// Reset: asynchronous, active low; attitude returns to identity, time_step to 16777.
`default_nettype none
module gyro_quaternion_integrator_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // gyro sample channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [gqi_pkg::RATE_W-1:0]  rate_x,
    input  wire logic signed [gqi_pkg::RATE_W-1:0]  rate_y,
    input  wire logic signed [gqi_pkg::RATE_W-1:0]  rate_z,
    // attitude result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [gqi_pkg::Q_W-1:0]          out_w,
    output logic signed [gqi_pkg::Q_W-1:0]          out_x,
    output logic signed [gqi_pkg::Q_W-1:0]          out_y,
    output logic signed [gqi_pkg::Q_W-1:0]          out_z,
    output logic                                    collapsed,
    // time_step write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gqi_pkg::TS_W-1:0]           cfg_data
);

    localparam int RW  = gqi_pkg::RATE_W;
    localparam int QW  = gqi_pkg::Q_W;
    localparam int AW  = gqi_pkg::MUL_AW;
    localparam int BW  = gqi_pkg::MUL_BW;
    localparam int PW  = gqi_pkg::MUL_PW;
    localparam int NB  = gqi_pkg::MUL_NB;
    localparam int PSW = gqi_pkg::P_W;
    localparam int VW  = gqi_pkg::V_W;
    localparam int MGW = gqi_pkg::MG_W;
    localparam int MSW = gqi_pkg::MS_W;
    localparam int NW  = gqi_pkg::N_W;
    localparam int RTW = gqi_pkg::R_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_TERM      = 4'd1;
    localparam logic [3:0] ST_TERM_WAIT = 4'd2;
    localparam logic [3:0] ST_STEP      = 4'd3;
    localparam logic [3:0] ST_STEP_WAIT = 4'd4;
    localparam logic [3:0] ST_NORM      = 4'd5;
    localparam logic [3:0] ST_SQ        = 4'd6;
    localparam logic [3:0] ST_SQ_WAIT   = 4'd7;
    localparam logic [3:0] ST_CHECK     = 4'd8;
    localparam logic [3:0] ST_ROOT      = 4'd9;
    localparam logic [3:0] ST_DIV_LOAD  = 4'd10;
    localparam logic [3:0] ST_DIV       = 4'd11;
    localparam logic [3:0] ST_DIV_STORE = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    localparam logic [NB-1:0] NB_RATE = NB'(RW);
    localparam logic [NB-1:0] NB_TS   = NB'(gqi_pkg::TS_W);
    localparam logic [NB-1:0] NB_SQ   = NB'(MSW);

    logic [3:0]                   state_reg, state_next;
    logic [1:0]                   comp_reg, comp_next;    // quaternion component
    logic [1:0]                   t_reg, t_next;          // term within a component
    logic [4:0]                   cnt_reg, cnt_next;      // root / divide step count
    logic [gqi_pkg::TS_W-1:0]     ts_reg, ts_next;
    logic signed [RW-1:0]         rate_reg [3];
    logic signed [RW-1:0]         rate_next [3];
    logic signed [QW-1:0]         att_reg [4];
    logic signed [QW-1:0]         att_next [4];
    logic signed [PSW-1:0]        p_reg, p_next;
    logic                         neg_reg, neg_next;
    logic signed [VW-1:0]         v_reg [4];
    logic signed [VW-1:0]         v_next [4];
    logic [MSW-1:0]               mgs_reg [4];
    logic [MSW-1:0]               mgs_next [4];
    logic [2:0]                   s_reg, s_next;
    logic [NW-1:0]                n_reg, n_next;
    logic [NW-1:0]                sqn_reg, sqn_next;
    logic [NW-1:0]                res_reg, res_next;
    logic [NW-1:0]                bit_reg, bit_next;
    logic [RTW-1:0]               root_reg, root_next;
    logic [RTW-1:0]               rem_reg, rem_next;
    logic [MSW-1:0]               dd_reg, dd_next;
    logic [MSW-1:0]               quo_reg, quo_next;
    logic                         coll_reg, coll_next;
    logic                         ov_reg, ov_next;
    logic signed [QW-1:0]         ow_reg, ow_next, ox_reg, ox_next;
    logic signed [QW-1:0]         oy_reg, oy_next, oz_reg, oz_next;
    logic                         oc_reg, oc_next;

    gqi_pkg::mul_ctl_t            mul_ctl;
    logic [AW-1:0]                mul_a;
    logic [BW-1:0]                mul_b;
    logic                         mul_busy;
    logic [PW-1:0]                mul_p;

    // term decode
    logic [3:0]                   k;
    logic [1:0]                   kq, kw;
    logic signed [QW-1:0]         q_sel;
    logic signed [RW-1:0]         w_sel;
    logic [QW-2:0]                q_mag;
    logic [RW-1:0]                w_mag;

    // rounding of p to Q.30 and delta
    logic [PSW-1:0]               p_mag, p_rnd;
    logic [59:0]                  d_sum;
    logic [34:0]                  d_val;

    // norm
    logic [MGW-1:0]               v_mag [4];
    logic [MGW-1:0]               v_or;
    logic [2:0]                   s_val;

    // root step
    logic [NW-1:0]                root_try;
    logic [NW-1:0]                res_step;

    // divide step
    logic [61:0]                  div_d;
    logic [RTW:0]                 rem_sh;
    logic                         q_bit;
    logic [MSW-1:0]               quo_sat;
    logic [MSW-1:0]               quo_shift;

    assign k     = {comp_reg, 1'b0} + {2'b00, comp_reg} + {2'b00, t_reg};
    assign kq    = gqi_pkg::term_q(k);
    assign kw    = gqi_pkg::term_w(k);
    assign q_sel = att_reg[kq];
    assign w_sel = rate_reg[kw];
    assign q_mag = q_sel[QW-1] ? (QW-1)'(-q_sel) : q_sel[QW-2:0];
    assign w_mag = w_sel[RW-1] ? RW'(-w_sel) : w_sel;

    // round half away from zero on the magnitude, drop 11 fraction bits
    assign p_mag = p_reg[PSW-1] ? PSW'(-p_reg) : p_reg;
    assign p_rnd = p_mag + PSW'(1024);
    // delta = round(|p30| * dt / 2^25)
    assign d_sum = mul_p[59:0] + 60'd16777216;
    assign d_val = d_sum[59:25];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            v_mag[i] = v_reg[i][VW-1] ? MGW'(-v_reg[i]) : v_reg[i][MGW-1:0];
        end
    end

    // leading bit of the largest magnitude equals that of the OR of all of them
    assign v_or = v_mag[0] | v_mag[1] | v_mag[2] | v_mag[3];
    always_comb
    begin
        priority if (v_or[35]) s_val = 3'd5;
        else if (v_or[34])     s_val = 3'd4;
        else if (v_or[33])     s_val = 3'd3;
        else if (v_or[32])     s_val = 3'd2;
        else if (v_or[31])     s_val = 3'd1;
        else                   s_val = 3'd0;
    end

    assign root_try = res_reg + bit_reg;
    assign res_step = (sqn_reg >= root_try) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    // dividend (|v| << 30) + r/2; quotient needs 31 bits because |v| never exceeds r
    assign div_d     = {1'b0, mgs_reg[comp_reg], 30'd0} + {31'd0, root_reg[RTW-1:1]};
    assign rem_sh    = {rem_reg, dd_reg[MSW-1]};
    assign q_bit     = rem_sh >= {1'b0, root_reg};
    assign quo_shift = {quo_reg[MSW-2:0], q_bit};
    assign quo_sat   = (quo_reg > MSW'(gqi_pkg::Q_ONE)) ? MSW'(gqi_pkg::Q_ONE) : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        ts_next    = ts_reg;
        rate_next  = rate_reg;
        att_next   = att_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        v_next     = v_reg;
        mgs_next   = mgs_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        sqn_next   = sqn_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        dd_next    = dd_reg;
        quo_next   = quo_reg;
        coll_next  = coll_reg;
        ov_next    = ov_reg;
        ow_next    = ow_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        oc_next    = oc_reg;
        mul_ctl    = '{start: 1'b0, nbits: NB_RATE};
        mul_a      = '0;
        mul_b      = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            ts_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rate_next[0] = rate_x;
                    rate_next[1] = rate_y;
                    rate_next[2] = rate_z;
                    p_next       = '0;
                    comp_next    = 2'd0;
                    t_next       = 2'd0;
                    state_next   = ST_TERM;
                end
            end
            ST_TERM:
            begin
                mul_ctl    = '{start: 1'b1, nbits: NB_RATE};
                mul_a      = AW'(q_mag);
                mul_b      = BW'(w_mag);
                neg_next   = gqi_pkg::term_neg(k) ^ q_sel[QW-1] ^ w_sel[RW-1];
                state_next = ST_TERM_WAIT;
            end
            ST_TERM_WAIT:
            begin
                if (!mul_busy)
                begin
                    p_next = neg_reg ? p_reg - $signed({1'b0, mul_p[46:0]})
                                     : p_reg + $signed({1'b0, mul_p[46:0]});
                    if (t_reg == 2'd2)
                    begin
                        t_next     = 2'd0;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        t_next     = t_reg + 2'd1;
                        state_next = ST_TERM;
                    end
                end
            end
            ST_STEP:
            begin
                mul_ctl    = '{start: 1'b1, nbits: NB_TS};
                mul_a      = p_rnd[46:11];
                mul_b      = BW'(ts_reg);
                neg_next   = p_reg[PSW-1];
                state_next = ST_STEP_WAIT;
            end
            ST_STEP_WAIT:
            begin
                if (!mul_busy)
                begin
                    v_next[comp_reg] = neg_reg ?
                        VW'(att_reg[comp_reg]) - $signed({2'b00, d_val}) :
                        VW'(att_reg[comp_reg]) + $signed({2'b00, d_val});
                    p_next = '0;
                    comp_next = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd3) ? ST_NORM : ST_TERM;
                end
            end
            ST_NORM:
            begin
                s_next = s_val;
                for (int i = 0; i < 4; i++)
                begin
                    mgs_next[i] = MSW'(v_mag[i] >> s_val);
                end
                n_next     = '0;
                comp_next  = 2'd0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mul_ctl    = '{start: 1'b1, nbits: NB_SQ};
                mul_a      = AW'(mgs_reg[comp_reg]);
                mul_b      = mgs_reg[comp_reg];
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (!mul_busy)
                begin
                    n_next     = n_reg + {2'b00, mul_p[61:0]};
                    comp_next  = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd3) ? ST_CHECK : ST_SQ;
                end
            end
            ST_CHECK:
            begin
                if (s_reg == 3'd0 && n_reg < gqi_pkg::COLLAPSE_TH)
                begin
                    // norm too small: back to identity
                    att_next[0] = gqi_pkg::Q_ONE;
                    att_next[1] = '0;
                    att_next[2] = '0;
                    att_next[3] = '0;
                    coll_next   = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    sqn_next   = n_reg;
                    res_next   = '0;
                    bit_next   = NW'(1) << 62;
                    cnt_next   = 5'd31;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqn_reg >= root_try)
                begin
                    sqn_next = sqn_reg - root_try;
                end
                res_next = res_step;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    root_next  = (res_step[RTW-1:0] == '0) ? RTW'(1) : res_step[RTW-1:0];
                    comp_next  = 2'd0;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                rem_next   = {1'b0, div_d[61:31]};
                dd_next    = div_d[30:0];
                quo_next   = '0;
                cnt_next   = 5'd30;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = q_bit ? RTW'(rem_sh - {1'b0, root_reg}) : rem_sh[RTW-1:0];
                quo_next = quo_shift;
                dd_next  = {dd_reg[MSW-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE:
            begin
                att_next[comp_reg] = v_reg[comp_reg][VW-1] ? -$signed({1'b0, quo_sat})
                                                            : $signed({1'b0, quo_sat});
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd3)
                begin
                    coll_next  = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_OUT:
            begin
                // output register free, or emptied in this same cycle
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ow_next    = att_reg[0];
                    ox_next    = att_reg[1];
                    oy_next    = att_reg[2];
                    oz_next    = att_reg[3];
                    oc_next    = coll_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            t_reg     <= '0;
            cnt_reg   <= '0;
            ts_reg    <= gqi_pkg::TS_RESET;
            att_reg[0] <= gqi_pkg::Q_ONE;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            t_reg     <= t_next;
            cnt_reg   <= cnt_next;
            ts_reg    <= ts_next;
            att_reg   <= att_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
        p_reg    <= p_next;
        neg_reg  <= neg_next;
        v_reg    <= v_next;
        mgs_reg  <= mgs_next;
        s_reg    <= s_next;
        n_reg    <= n_next;
        sqn_reg  <= sqn_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        dd_reg   <= dd_next;
        quo_reg  <= quo_next;
        coll_reg <= coll_next;
        ow_reg   <= ow_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        oc_reg   <= oc_next;
    end

    gqi_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_p)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_w     = ow_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign collapsed = oc_reg;

`ifndef SYNTHESIS
    // a collapse result always carries the identity
    a_collapse_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && collapsed) |-> (out_w == gqi_pkg::Q_ONE && out_x == '0 &&
                                      out_y == '0 && out_z == '0))
        else $error("collapse result is not identity");

    // normalised components stay inside [-1, 1] in Q1.30
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_w <= gqi_pkg::Q_ONE && out_w >= -gqi_pkg::Q_ONE &&
                       out_x <= gqi_pkg::Q_ONE && out_x >= -gqi_pkg::Q_ONE &&
                       out_y <= gqi_pkg::Q_ONE && out_y >= -gqi_pkg::Q_ONE &&
                       out_z <= gqi_pkg::Q_ONE && out_z >= -gqi_pkg::Q_ONE))
        else $error("result component out of range");

    // the multiplier is only ever running while a sample is in work
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_OUT) |-> !mul_busy)
        else $error("multiplier busy outside a computation");
`endif

endmodule
`default_nettype wire
